// ===== hdl/multi_channel_range_qualifier_assert.svh =====
// assertion macros shared by the range qualifier rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef MULTI_CHANNEL_RANGE_QUALIFIER_ASSERT_SVH
`define MULTI_CHANNEL_RANGE_QUALIFIER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MCRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MCRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcrq_pkg.sv =====
// types, constants and register codes for the multi-channel range qualifier
// no dependencies
`default_nettype none

package mcrq_pkg;

    localparam int unsigned CHANNELS = 4;

    localparam logic [15:0] INVALID_MM = 16'hFFFF;
    localparam logic [9:0]  STUCK_MIN  = 10'd10;
    localparam logic [9:0]  STUCK_MAX  = 10'd1000;
    localparam logic [9:0]  WAIT_SAT   = 10'd1023;
    localparam logic [7:0]  NEAR_SAT   = 8'd255;

    localparam logic [3:0]  RST_ACTIVE_MASK    = 4'd15;
    localparam logic [9:0]  RST_STUCK_LIMIT    = 10'd50;
    localparam logic [15:0] RST_MIN_VALID_MM   = 16'd20;
    localparam logic [15:0] RST_MAX_VALID_MM   = 16'd8000;
    localparam logic [15:0] RST_NEAR_LIMIT_MM  = 16'd150;
    localparam logic [7:0]  RST_CONFIRM_FRAMES = 8'd3;

    typedef enum logic [2:0] {
        REG_ACTIVE_MASK    = 3'd0,
        REG_STUCK_LIMIT    = 3'd1,
        REG_MIN_VALID_MM   = 3'd2,
        REG_MAX_VALID_MM   = 3'd3,
        REG_NEAR_LIMIT_MM  = 3'd4,
        REG_CONFIRM_FRAMES = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]  active_mask;
        logic [9:0]  stuck_limit;
        logic [15:0] min_valid_mm;
        logic [15:0] max_valid_mm;
        logic [15:0] near_limit_mm;
        logic [7:0]  confirm_frames;
    } cfg_t;

    typedef struct packed {
        logic        in_flight;
        logic [9:0]  wait_ticks;
        logic        empty_latch;
        logic [7:0]  near_count;
        logic [15:0] last_distance;
    } chan_state_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic        sensor_ready;
        logic        start_ok;
        logic        poll_ok;
        logic        meas_done;
        logic        fetch_ok;
        logic [15:0] raw_mm;
        logic [7:0]  meas_status;
    } item_t;

    typedef struct packed {
        logic [1:0]  out_channel;
        logic [15:0] distance;
        logic        measuring;
        logic        timed_out;
        logic        consumed;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/multi_channel_range_qualifier.sv =====
// Multi-channel range qualifier: one polling visit per transaction, one result per visit.
// A visit is taken into an input register; in the next stage the visited channel's state is
// read from flip-flops, updated by mcrq_core and written back in the same cycle the result
// enters the output register, so while m_tready stays high a visit may follow in every cycle,
// even to the same channel, and throughput is one transaction per clock. s_tready drops only
// while both registers are full and m_tready is low. The user must write configuration via
// the APB port only while no visit is in progress; the block itself does not enforce this.
// depends on mcrq_pkg, mcrq_core and multi_channel_range_qualifier_assert.svh
`default_nettype none
`include "multi_channel_range_qualifier_assert.svh"

module multi_channel_range_qualifier
    import mcrq_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    // apb configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // visit stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // [0] sensor_ready, [1] start_ok, [2] poll_ok, [3] meas_done, [4] fetch_ok,
    // [20:5] raw_mm, [28:21] meas_status, [31:29] zero
    input  wire  [31:0] s_tdata,
    // [1:0] channel
    input  wire  [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // [15:0] distance, [16] measuring, [17] timed_out, [18] consumed, [23:19] zero
    output logic [23:0] m_tdata,
    // [1:0] out_channel
    output logic [1:0]  m_tuser
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    chan_state_t state_reg [CHANNELS];

    logic        cfg_wr;
    logic [9:0]  stuck_wr;
    logic        advance;
    logic        chan_hit;
    chan_state_t cur_state;
    chan_state_t upd_state;
    result_t     core_res;
    result_t     res_next;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        stuck_wr = pwdata[9:0];
        if (stuck_wr < STUCK_MIN)
            stuck_wr = STUCK_MIN;
        else if (stuck_wr > STUCK_MAX)
            stuck_wr = STUCK_MAX;

        cfg_next = cfg_reg;
        unique case (paddr[4:2])
            REG_ACTIVE_MASK:    cfg_next.active_mask    = pwdata[3:0];
            REG_STUCK_LIMIT:    cfg_next.stuck_limit    = stuck_wr;
            REG_MIN_VALID_MM:   cfg_next.min_valid_mm   = pwdata[15:0];
            REG_MAX_VALID_MM:   cfg_next.max_valid_mm   = pwdata[15:0];
            REG_NEAR_LIMIT_MM:  cfg_next.near_limit_mm  = pwdata[15:0];
            REG_CONFIRM_FRAMES: cfg_next.confirm_frames = pwdata[7:0];
            default:            cfg_next = cfg_reg;
        endcase
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ACTIVE_MASK:    prdata = {28'd0, cfg_reg.active_mask};
            REG_STUCK_LIMIT:    prdata = {22'd0, cfg_reg.stuck_limit};
            REG_MIN_VALID_MM:   prdata = {16'd0, cfg_reg.min_valid_mm};
            REG_MAX_VALID_MM:   prdata = {16'd0, cfg_reg.max_valid_mm};
            REG_NEAR_LIMIT_MM:  prdata = {16'd0, cfg_reg.near_limit_mm};
            REG_CONFIRM_FRAMES: prdata = {24'd0, cfg_reg.confirm_frames};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_mask    <= RST_ACTIVE_MASK;
            cfg_reg.stuck_limit    <= RST_STUCK_LIMIT;
            cfg_reg.min_valid_mm   <= RST_MIN_VALID_MM;
            cfg_reg.max_valid_mm   <= RST_MAX_VALID_MM;
            cfg_reg.near_limit_mm  <= RST_NEAR_LIMIT_MM;
            cfg_reg.confirm_frames <= RST_CONFIRM_FRAMES;
        end
        else if (cfg_wr)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline control
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.channel      <= s_tuser;
            in_item_reg.sensor_ready <= s_tdata[0];
            in_item_reg.start_ok     <= s_tdata[1];
            in_item_reg.poll_ok      <= s_tdata[2];
            in_item_reg.meas_done    <= s_tdata[3];
            in_item_reg.fetch_ok     <= s_tdata[4];
            in_item_reg.raw_mm       <= s_tdata[20:5];
            in_item_reg.meas_status  <= s_tdata[28:21];
        end
        if (advance)
            out_res_reg <= res_next;
    end

    // channel state update
    assign chan_hit  = 32'(in_item_reg.channel) < CHANNELS;
    assign cur_state = state_reg[in_item_reg.channel];

    mcrq_core u_core (
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .state      (cur_state),
        .state_next (upd_state),
        .res        (core_res)
    );

    always_comb
    begin
        res_next = core_res;
        if (!chan_hit)
        begin
            res_next.distance  = INVALID_MM;
            res_next.measuring = 1'b0;
            res_next.timed_out = 1'b0;
            res_next.consumed  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                state_reg[i] <= '0;
        end
        else if (advance && chan_hit)
        begin
            state_reg[in_item_reg.channel] <= upd_state;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.out_channel;
    assign m_tdata  = {5'd0, out_res_reg.consumed, out_res_reg.timed_out,
                       out_res_reg.measuring, out_res_reg.distance};

    // checks
    `MCRQ_ASSERT_NOW(a_stuck_in_range,
        1'b1, (cfg_reg.stuck_limit >= STUCK_MIN) && (cfg_reg.stuck_limit <= STUCK_MAX),
        "stuck limit outside its saturated range")
    `MCRQ_ASSERT_NOW(a_timeout_invalid,
        out_valid_reg && out_res_reg.timed_out,
        !out_res_reg.consumed && !out_res_reg.measuring && (out_res_reg.distance == INVALID_MM),
        "timed out result with live measurement or distance")
    `MCRQ_ASSERT_NOW(a_consumed_idle,
        out_valid_reg && out_res_reg.consumed, !out_res_reg.measuring,
        "consumed result still reports a measurement in flight")
    `MCRQ_ASSERT_NEXT(a_disabled_cleared,
        advance && chan_hit && !cfg_reg.active_mask[in_item_reg.channel],
        !state_reg[$past(in_item_reg.channel)].in_flight
            && state_reg[$past(in_item_reg.channel)].empty_latch,
        "disabled channel not reset")

endmodule

`default_nettype wire

// ===== hdl/mcrq_core.sv =====
// per-visit channel update: start, poll, stuck timeout and reading qualification
// depends on mcrq_pkg
`default_nettype none

module mcrq_core
    import mcrq_pkg::*;
(
    input  wire cfg_t        cfg,
    input  wire item_t       item,
    input  wire chan_state_t state,
    output chan_state_t      state_next,
    output result_t          res
);

    logic        enabled;
    logic [9:0]  wait_inc;
    logic [7:0]  near_inc;
    logic        bad_reading;
    logic        timed_out;
    logic        consumed;
    chan_state_t abandoned;

    always_comb
    begin
        enabled     = cfg.active_mask[item.channel] & item.sensor_ready;
        wait_inc    = (state.wait_ticks == WAIT_SAT) ? WAIT_SAT : state.wait_ticks + 10'd1;
        near_inc    = (state.near_count == NEAR_SAT) ? NEAR_SAT : state.near_count + 8'd1;
        bad_reading = (item.meas_status != 8'd0) || (item.raw_mm < cfg.min_valid_mm)
                      || (item.raw_mm >= cfg.max_valid_mm);

        abandoned               = state;
        abandoned.last_distance = INVALID_MM;
        abandoned.in_flight     = 1'b0;
        abandoned.wait_ticks    = '0;
        abandoned.empty_latch   = 1'b1;
        abandoned.near_count    = '0;

        state_next = state;
        timed_out  = 1'b0;
        consumed   = 1'b0;

        if (!enabled)
        begin
            state_next = abandoned;
        end
        else if (!state.in_flight)
        begin
            if (item.start_ok)
            begin
                state_next.in_flight  = 1'b1;
                state_next.wait_ticks = '0;
            end
            else
            begin
                state_next = abandoned;
            end
        end
        else if (!item.poll_ok)
        begin
            state_next = abandoned;
        end
        else if (!item.meas_done)
        begin
            if (wait_inc >= cfg.stuck_limit)
            begin
                state_next = abandoned;
                timed_out  = 1'b1;
            end
            else
            begin
                state_next.wait_ticks = wait_inc;
            end
        end
        else
        begin
            consumed              = 1'b1;
            state_next.in_flight  = 1'b0;
            state_next.wait_ticks = '0;
            if (!item.fetch_ok || bad_reading)
            begin
                state_next.last_distance = INVALID_MM;
                state_next.empty_latch   = 1'b1;
                state_next.near_count    = '0;
            end
            else if (state.empty_latch && (item.raw_mm <= cfg.near_limit_mm)
                     && (near_inc < cfg.confirm_frames))
            begin
                state_next.last_distance = INVALID_MM;
                state_next.near_count    = near_inc;
            end
            else
            begin
                state_next.last_distance = item.raw_mm;
                state_next.empty_latch   = 1'b0;
                state_next.near_count    = '0;
            end
        end

        res.out_channel = item.channel;
        res.distance    = state_next.last_distance;
        res.measuring   = state_next.in_flight;
        res.timed_out   = timed_out;
        res.consumed    = consumed;
    end

endmodule

`default_nettype wire
